[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BMMC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define BMMC_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define BMMC_ASSERT(label, clk, rst, prop, msg)

`define BMMC_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

[hw/rtl/bmmc_pkg.sv]
// Types, constants and helper functions for the button mode motor controller.
// No dependencies; used by bmmc_step and the top level.
`default_nettype none

package bmmc_pkg;

   localparam int QUARTER_BITS_DEFAULT = 5;
   localparam int PULSE_A_BITS_DEFAULT = 4;
   localparam int PULSE_B_BITS_DEFAULT = 6;

   localparam logic [7:0] DUTY_MAX = 8'd244;

   localparam logic [2:0] MODE_LOW       = 3'd0;
   localparam logic [2:0] MODE_MID       = 3'd1;
   localparam logic [2:0] MODE_HIGH      = 3'd2;
   localparam logic [2:0] MODE_PULSE_A   = 3'd3;
   localparam logic [2:0] MODE_PULSE_B   = 3'd4;
   localparam logic [2:0] MODE_LAST      = MODE_PULSE_B;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_DEBOUNCE    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHARGE_DEBOUNCE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLEEP           = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_LOW        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_MID        = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_HIGH       = 3'd6;

   localparam logic [7:0] KEY_DEBOUNCE_RESET    = 8'd4;
   localparam logic [7:0] CHARGE_DEBOUNCE_RESET = 8'd8;
   localparam logic [7:0] LONG_PRESS_RESET      = 8'd8;
   localparam logic [7:0] SLEEP_RESET           = 8'd40;
   localparam logic [7:0] DUTY_LOW_RESET        = 8'd80;
   localparam logic [7:0] DUTY_MID_RESET        = 8'd160;
   localparam logic [7:0] DUTY_HIGH_RESET       = 8'd244;

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 16;

   typedef struct packed {
      logic [7:0] key_debounce_ticks;
      logic [7:0] charge_debounce_ticks;
      logic [7:0] long_press_quarters;
      logic [7:0] sleep_quarters;
      logic [7:0] duty_low;
      logic [7:0] duty_mid;
      logic [7:0] duty_high;
   } bmmc_cfg_type;

   typedef struct packed {
      logic [15:0] tick_count;
      logic [7:0]  press_timer;
      logic [7:0]  release_timer;
      logic        press_stable;
      logic        release_stable;
      logic        key_held;
      logic [7:0]  hold_timer;
      logic        long_press_done;
      logic        press_counted;
      logic [2:0]  press_mode;
      logic        load_active;
      logic [7:0]  idle_timer;
      logic        idle_flag;
      logic [7:0]  charge_timer;
      logic        charge_stable;
      logic        previous_key;
   } bmmc_state_type;

   typedef struct packed {
      logic       sleep_request;
      logic       charging;
      logic       load_on;
      logic [2:0] mode;
      logic       pwm_enable;
      logic [7:0] duty;
   } bmmc_result_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic logic [7:0] clamp_duty(input logic [7:0] d);
      return (d > DUTY_MAX) ? DUTY_MAX : d;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bmmc_step.sv]
// Next-state and result logic for one timer tick of the controller.
// Depends on bmmc_pkg for the state, configuration and result types.
`default_nettype none

module bmmc_step #(
   parameter int QUARTER_BITS = bmmc_pkg::QUARTER_BITS_DEFAULT,
   parameter int PULSE_A_BITS = bmmc_pkg::PULSE_A_BITS_DEFAULT,
   parameter int PULSE_B_BITS = bmmc_pkg::PULSE_B_BITS_DEFAULT
) (
   input  bmmc_pkg::bmmc_state_type  cur_i,
   input  bmmc_pkg::bmmc_cfg_type    cfg_i,
   input  logic                      key_i,
   input  logic                      chrg_i,
   output bmmc_pkg::bmmc_state_type  nxt_o,
   output bmmc_pkg::bmmc_result_type res_o
);
   import bmmc_pkg::*;

   always_comb begin
      bmmc_state_type s;
      logic           charging;
      logic           enable;
      logic           sleep_req;
      logic [7:0]     duty;
      s         = cur_i;
      enable    = 1'b0;
      sleep_req = 1'b0;
      duty      = 8'd0;

      if (key_i && !s.previous_key) begin
         s.idle_flag  = 1'b0;
         s.idle_timer = 8'd0;
      end
      s.previous_key = key_i;

      s.tick_count = s.tick_count + 16'd1;
      if (s.tick_count[QUARTER_BITS-1:0] == '0) begin
         if (s.key_held && !s.long_press_done) begin
            s.hold_timer = sat_inc(s.hold_timer);
            if (s.hold_timer >= cfg_i.long_press_quarters) begin
               s.long_press_done = 1'b1;
               s.load_active     = !s.load_active;
            end
         end
         if (!s.load_active && !s.idle_flag) begin
            s.idle_timer = sat_inc(s.idle_timer);
            if (s.idle_timer >= cfg_i.sleep_quarters) begin
               s.idle_flag = 1'b1;
            end
         end
      end

      if (key_i && !s.press_stable) begin
         s.press_timer = sat_inc(s.press_timer);
         if (s.press_timer >= cfg_i.key_debounce_ticks) begin
            s.press_stable = 1'b1;
         end
      end
      if (!key_i && !s.release_stable) begin
         s.release_timer = sat_inc(s.release_timer);
         if (s.release_timer >= cfg_i.key_debounce_ticks) begin
            s.release_stable = 1'b1;
         end
      end
      if (chrg_i && !s.charge_stable) begin
         s.charge_timer = sat_inc(s.charge_timer);
         if (s.charge_timer >= cfg_i.charge_debounce_ticks) begin
            s.charge_stable = 1'b1;
         end
      end

      if (!key_i) begin
         s.press_stable = 1'b0;
         s.press_timer  = 8'd0;
         if (s.release_stable) begin
            s.key_held = 1'b0;
         end
      end else begin
         s.release_stable = 1'b0;
         s.release_timer  = 8'd0;
         if (s.press_stable) begin
            s.key_held = 1'b1;
         end
      end
      if (s.key_held && !s.press_counted) begin
         s.press_counted = 1'b1;
         s.press_mode    = (s.press_mode >= MODE_LAST) ? MODE_LOW : s.press_mode + 3'd1;
      end
      if (!s.key_held) begin
         s.long_press_done = 1'b0;
         s.hold_timer      = 8'd0;
         s.press_counted   = 1'b0;
      end
      if (!s.load_active) begin
         s.press_mode = MODE_LOW;
      end else begin
         s.idle_flag  = 1'b0;
         s.idle_timer = 8'd0;
      end

      charging = s.charge_stable;
      if (!chrg_i) begin
         s.charge_stable = 1'b0;
         s.charge_timer  = 8'd0;
      end

      if (charging) begin
         s.load_active = 1'b0;
      end
      if (s.load_active) begin
         case (s.press_mode)
            MODE_LOW: begin
               duty   = clamp_duty(cfg_i.duty_low);
               enable = 1'b1;
            end
            MODE_MID: begin
               duty   = clamp_duty(cfg_i.duty_mid);
               enable = 1'b1;
            end
            MODE_HIGH: begin
               duty   = clamp_duty(cfg_i.duty_high);
               enable = 1'b1;
            end
            MODE_PULSE_A: begin
               duty   = clamp_duty(cfg_i.duty_high);
               enable = !s.tick_count[PULSE_A_BITS-1];
            end
            MODE_PULSE_B: begin
               duty   = clamp_duty(cfg_i.duty_mid);
               enable = !s.tick_count[PULSE_B_BITS-1];
            end
            default: begin
               duty   = 8'd0;
               enable = 1'b0;
            end
         endcase
      end

      if (s.idle_flag) begin
         sleep_req    = 1'b1;
         s.idle_flag  = 1'b0;
         s.idle_timer = 8'd0;
      end

      nxt_o               = s;
      res_o.duty          = duty;
      res_o.pwm_enable    = enable;
      res_o.mode          = s.press_mode;
      res_o.load_on       = s.load_active;
      res_o.charging      = charging;
      res_o.sleep_request = sleep_req;
   end

endmodule

`default_nettype wire

[hw/rtl/button_mode_motor_controller_top.sv]
// Top level of the button mode motor controller: stream ports, control registers,
// controller state and result register. Depends on bmmc_pkg, bmmc_step, assert_macros.svh.
//
// Each request beat is one timer tick carrying the sampled key and charger levels;
// it yields exactly one response beat with duty, PWM enable, mode, load, charging
// and sleep request. The request is taken into the state
// and result registers at the edge where it is accepted, and the response is valid
// the next cycle. A new tick is accepted every cycle as long as the response
// register is empty or being read in the same cycle, so throughput is one tick per
// clock. A quarter second is 2^QUARTER_BITS ticks. Control registers are written
// through the csr_ port and should only be changed while no tick is in flight.
`default_nettype none

module button_mode_motor_controller_top #(
   parameter int QUARTER_BITS = bmmc_pkg::QUARTER_BITS_DEFAULT,
   parameter int PULSE_A_BITS = bmmc_pkg::PULSE_A_BITS_DEFAULT,
   parameter int PULSE_B_BITS = bmmc_pkg::PULSE_B_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  s_axis_req_tvalid,
   output logic                                  s_axis_req_tready,
   // Bit 0 key_down, bit 1 charger_present, the rest zero.
   input  logic [bmmc_pkg::REQ_DATA_WIDTH-1:0]   s_axis_req_tdata,
   output logic                                  m_axis_rsp_tvalid,
   input  logic                                  m_axis_rsp_tready,
   // Bits 7:0 duty, 8 pwm_enable, 11:9 mode, 12 load_on, 13 charging,
   // 14 sleep_request, 15 zero.
   output logic [bmmc_pkg::RSP_DATA_WIDTH-1:0]   m_axis_rsp_tdata,
   input  logic                                  csr_we,
   input  logic [bmmc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [7:0]                            csr_wdata
);
   import bmmc_pkg::*;

`include "assert_macros.svh"

   bmmc_cfg_type    cfg_ff, cfg_in;
   bmmc_state_type  state_ff, state_in;
   bmmc_state_type  step_nxt;
   bmmc_result_type step_res;
   bmmc_result_type res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_accept;

   assign s_axis_req_tready = !rsp_valid_ff || m_axis_rsp_tready;
   assign req_accept        = s_axis_req_tvalid && s_axis_req_tready;

   bmmc_step #(
      .QUARTER_BITS(QUARTER_BITS),
      .PULSE_A_BITS(PULSE_A_BITS),
      .PULSE_B_BITS(PULSE_B_BITS)
   ) u_step (
      .cur_i (state_ff),
      .cfg_i (cfg_ff),
      .key_i (s_axis_req_tdata[0]),
      .chrg_i(s_axis_req_tdata[1]),
      .nxt_o (step_nxt),
      .res_o (step_res)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_DEBOUNCE:    cfg_in.key_debounce_ticks    = csr_wdata;
            CSR_CHARGE_DEBOUNCE: cfg_in.charge_debounce_ticks = csr_wdata;
            CSR_LONG_PRESS:      cfg_in.long_press_quarters   = csr_wdata;
            CSR_SLEEP:           cfg_in.sleep_quarters        = csr_wdata;
            CSR_DUTY_LOW:        cfg_in.duty_low              = csr_wdata;
            CSR_DUTY_MID:        cfg_in.duty_mid              = csr_wdata;
            CSR_DUTY_HIGH:       cfg_in.duty_high             = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = req_accept ? step_nxt : state_ff;
      res_in       = req_accept ? step_res : res_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !m_axis_rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_debounce_ticks    <= KEY_DEBOUNCE_RESET;
         cfg_ff.charge_debounce_ticks <= CHARGE_DEBOUNCE_RESET;
         cfg_ff.long_press_quarters   <= LONG_PRESS_RESET;
         cfg_ff.sleep_quarters        <= SLEEP_RESET;
         cfg_ff.duty_low              <= DUTY_LOW_RESET;
         cfg_ff.duty_mid              <= DUTY_MID_RESET;
         cfg_ff.duty_high             <= DUTY_HIGH_RESET;
         state_ff                     <= '0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign m_axis_rsp_tvalid = rsp_valid_ff;
   assign m_axis_rsp_tdata  = {1'b0, res_ff};

   `BMMC_ASSERT(a_mode_range, clock, reset, state_ff.press_mode <= MODE_LAST, "mode out of range")
   `BMMC_ASSERT(a_off_quiet, clock, reset, rsp_valid_ff && !res_ff.load_on |-> res_ff.duty == 8'd0 && !res_ff.pwm_enable, "output active while load off")
   `BMMC_ASSERT(a_duty_cap, clock, reset, rsp_valid_ff |-> res_ff.duty <= DUTY_MAX, "duty above limit")
   `BMMC_ASSERT_NEVER(a_sleep_load, clock, reset, rsp_valid_ff && res_ff.sleep_request && res_ff.load_on, "sleep request with load on")
   `BMMC_ASSERT(a_tick_step, clock, reset, req_accept |=> state_ff.tick_count == 16'($past(state_ff.tick_count) + 16'd1), "tick counter did not advance")

endmodule

`default_nettype wire
